### hdl/rbyuv_pkg.sv
package rbyuv_pkg;

   // Widths of the fixed-point datapath.
   localparam int SAMPLE_W = 8;
   localparam int SUM_W    = 27;  // holds one pixel's or four pixels' Q16 chroma sum
   localparam int LSUM_W   = 24;  // one pixel's luma sum with the rounding half
   localparam int FRAC_W   = 16;
   localparam int TRUNC_W  = SUM_W - FRAC_W;  // integer part of a chroma sum
   localparam int ADJ_W    = TRUNC_W + 1;     // after the move away from zero
   localparam int CHROMA_W = 10;

   localparam logic [SAMPLE_W-1:0] OFFSET_RESET = 8'd128;

   // Q16 weights.
   localparam logic signed [SUM_W-1:0] Y_R = 27'sd19595;
   localparam logic signed [SUM_W-1:0] Y_G = 27'sd38470;
   localparam logic signed [SUM_W-1:0] Y_B = 27'sd7471;
   localparam logic signed [SUM_W-1:0] U_R = -27'sd9634;
   localparam logic signed [SUM_W-1:0] U_G = -27'sd18940;
   localparam logic signed [SUM_W-1:0] U_B = 27'sd28574;
   localparam logic signed [SUM_W-1:0] V_R = 27'sd40305;
   localparam logic signed [SUM_W-1:0] V_G = -27'sd33751;
   localparam logic signed [SUM_W-1:0] V_B = -27'sd6554;
   localparam logic signed [SUM_W-1:0] Q16_HALF = 27'sd32768;

   localparam logic signed [CHROMA_W-1:0] CLAMP_LO = -10'sd128;
   localparam logic signed [CHROMA_W-1:0] CLAMP_HI = 10'sd127;

   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0] sum_type;

endpackage

### hdl/rbyuv_pixel.sv
module rbyuv_pixel (
   input  logic                   clock,
   input  rbyuv_pkg::sample_type  blue,
   input  rbyuv_pkg::sample_type  green,
   input  rbyuv_pkg::sample_type  red,
   output logic [rbyuv_pkg::LSUM_W-1:0] luma_sum,
   output rbyuv_pkg::sum_type     u_sum,
   output rbyuv_pkg::sum_type     v_sum
);

   rbyuv_pkg::sum_type b_s, g_s, r_s;
   rbyuv_pkg::sum_type y_full;
   logic [rbyuv_pkg::LSUM_W-1:0] luma_sum_ff;
   rbyuv_pkg::sum_type u_sum_ff, v_sum_ff;

   assign b_s = $signed({{(rbyuv_pkg::SUM_W-rbyuv_pkg::SAMPLE_W){1'b0}}, blue});
   assign g_s = $signed({{(rbyuv_pkg::SUM_W-rbyuv_pkg::SAMPLE_W){1'b0}}, green});
   assign r_s = $signed({{(rbyuv_pkg::SUM_W-rbyuv_pkg::SAMPLE_W){1'b0}}, red});

   // The luma weights add up to one, so the sum never leaves 24 bits.
   assign y_full = rbyuv_pkg::Y_R * r_s + rbyuv_pkg::Y_G * g_s + rbyuv_pkg::Y_B * b_s
                   + rbyuv_pkg::Q16_HALF;

   always_ff @(posedge clock) begin
      luma_sum_ff <= y_full[rbyuv_pkg::LSUM_W-1:0];
      u_sum_ff    <= rbyuv_pkg::U_R * r_s + rbyuv_pkg::U_G * g_s + rbyuv_pkg::U_B * b_s;
      v_sum_ff    <= rbyuv_pkg::V_R * r_s + rbyuv_pkg::V_G * g_s + rbyuv_pkg::V_B * b_s;
   end

   assign luma_sum = luma_sum_ff;
   assign u_sum    = u_sum_ff;
   assign v_sum    = v_sum_ff;

endmodule

### hdl/rbyuv_chroma.sv
module rbyuv_chroma (
   input  logic                  clock,
   input  rbyuv_pkg::sum_type    sum,
   input  rbyuv_pkg::sample_type offset,
   output logic signed [rbyuv_pkg::CHROMA_W-1:0] chroma
);

   logic signed [rbyuv_pkg::TRUNC_W-1:0]  whole;
   logic signed [rbyuv_pkg::ADJ_W-1:0]    adj_in, adj_ff;
   logic signed [rbyuv_pkg::CHROMA_W-1:0] quarter, clamped, chroma_in, chroma_ff;
   logic                                  round_up;

   // Truncation toward zero: a negative sum with a fraction rounds up by one.
   assign round_up = sum[rbyuv_pkg::SUM_W-1] && (sum[rbyuv_pkg::FRAC_W-1:0] != '0);
   assign whole    = sum[rbyuv_pkg::SUM_W-1:rbyuv_pkg::FRAC_W]
                     + $signed({{(rbyuv_pkg::TRUNC_W-1){1'b0}}, round_up});

   always_comb begin
      if (whole[rbyuv_pkg::TRUNC_W-1]) begin
         adj_in = rbyuv_pkg::ADJ_W'(whole) - rbyuv_pkg::ADJ_W'(2);
      end else begin
         adj_in = rbyuv_pkg::ADJ_W'(whole) + rbyuv_pkg::ADJ_W'(2);
      end
   end

   assign quarter = rbyuv_pkg::CHROMA_W'(adj_ff >>> 2);

   always_comb begin
      priority if (quarter < rbyuv_pkg::CLAMP_LO) begin
         clamped = rbyuv_pkg::CLAMP_LO;
      end else if (quarter > rbyuv_pkg::CLAMP_HI) begin
         clamped = rbyuv_pkg::CLAMP_HI;
      end else begin
         clamped = quarter;
      end
      chroma_in = clamped
                  + $signed({{(rbyuv_pkg::CHROMA_W-rbyuv_pkg::SAMPLE_W){1'b0}}, offset});
   end

   always_ff @(posedge clock) begin
      adj_ff    <= adj_in;
      chroma_ff <= chroma_in;
   end

   assign chroma = chroma_ff;

endmodule

### hdl/rgb_block_to_yuv420.sv
// Converts one 2x2 block of BGR pixels to four luma samples and one U and
// one V sample (BT.601 weights, Q16 fixed point).
// Input: an item is taken at a rising edge with start high and busy low.
// busy is always low, so a new item may enter on every clock.
// Output: each result appears for exactly one cycle with rsp_strobe high,
// in the order the items were taken; the receiver cannot stall.
// Pipeline: four register stages (pixel sums, luma and chroma totals, chroma
// truncation, clamp and offset); rsp_strobe is registered alongside the clamp
// and offset stage and marks the result that this stage holds.
// Throughput: one block per clock; every stage hands its item on at each edge.
// Configuration: csr_wdata is written into the chroma offset when
// csr_valid and csr_ready are both high; csr_ready is always high. Write it
// only while no item is in flight.
// Reset: synchronous, active high; empties the pipeline and sets the chroma
// offset to 128.
module rgb_block_to_yuv420 (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  rbyuv_pkg::sample_type req_tl_blue,
   input  rbyuv_pkg::sample_type req_tl_green,
   input  rbyuv_pkg::sample_type req_tl_red,
   input  rbyuv_pkg::sample_type req_tr_blue,
   input  rbyuv_pkg::sample_type req_tr_green,
   input  rbyuv_pkg::sample_type req_tr_red,
   input  rbyuv_pkg::sample_type req_bl_blue,
   input  rbyuv_pkg::sample_type req_bl_green,
   input  rbyuv_pkg::sample_type req_bl_red,
   input  rbyuv_pkg::sample_type req_br_blue,
   input  rbyuv_pkg::sample_type req_br_green,
   input  rbyuv_pkg::sample_type req_br_red,
   output logic                  rsp_strobe,
   output rbyuv_pkg::sample_type rsp_luma_tl,
   output rbyuv_pkg::sample_type rsp_luma_tr,
   output rbyuv_pkg::sample_type rsp_luma_bl,
   output rbyuv_pkg::sample_type rsp_luma_br,
   output logic signed [rbyuv_pkg::CHROMA_W-1:0] rsp_chroma_u,
   output logic signed [rbyuv_pkg::CHROMA_W-1:0] rsp_chroma_v,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  rbyuv_pkg::sample_type csr_wdata
);

   localparam int PIXELS = 4;
   localparam int STAGES = 4;

   rbyuv_pkg::sample_type        blue [PIXELS];
   rbyuv_pkg::sample_type        green[PIXELS];
   rbyuv_pkg::sample_type        red  [PIXELS];
   logic [rbyuv_pkg::LSUM_W-1:0] luma_sum[PIXELS];
   rbyuv_pkg::sum_type           u_sum[PIXELS];
   rbyuv_pkg::sum_type           v_sum[PIXELS];

   logic [STAGES-1:0]     valid_ff, valid_in;
   rbyuv_pkg::sample_type offset_ff, offset_in;
   rbyuv_pkg::sample_type luma2_ff[PIXELS];
   rbyuv_pkg::sample_type luma3_ff[PIXELS];
   rbyuv_pkg::sample_type luma4_ff[PIXELS];
   rbyuv_pkg::sum_type    u_total_ff, u_total_in, v_total_ff, v_total_in;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign blue  = '{req_tl_blue,  req_tr_blue,  req_bl_blue,  req_br_blue};
   assign green = '{req_tl_green, req_tr_green, req_bl_green, req_br_green};
   assign red   = '{req_tl_red,   req_tr_red,   req_bl_red,   req_br_red};

   for (genvar p = 0; p < PIXELS; p++) begin : g_pix
      rbyuv_pixel u_pixel (
         .clock    (clock),
         .blue     (blue[p]),
         .green    (green[p]),
         .red      (red[p]),
         .luma_sum (luma_sum[p]),
         .u_sum    (u_sum[p]),
         .v_sum    (v_sum[p])
      );
   end

   assign valid_in   = {valid_ff[STAGES-2:0], start & ~busy};
   assign offset_in  = (csr_valid && csr_ready) ? csr_wdata : offset_ff;
   assign u_total_in = u_sum[0] + u_sum[1] + u_sum[2] + u_sum[3];
   assign v_total_in = v_sum[0] + v_sum[1] + v_sum[2] + v_sum[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         offset_ff <= rbyuv_pkg::OFFSET_RESET;
      end else begin
         valid_ff  <= valid_in;
         offset_ff <= offset_in;
      end
   end

   // Luma is finished one stage after the pixel sums and then waits for chroma.
   always_ff @(posedge clock) begin
      for (int p = 0; p < PIXELS; p++) begin
         luma2_ff[p] <= luma_sum[p][rbyuv_pkg::LSUM_W-1:rbyuv_pkg::FRAC_W];
         luma3_ff[p] <= luma2_ff[p];
         luma4_ff[p] <= luma3_ff[p];
      end
      u_total_ff <= u_total_in;
      v_total_ff <= v_total_in;
   end

   rbyuv_chroma u_chroma_u (
      .clock  (clock),
      .sum    (u_total_ff),
      .offset (offset_ff),
      .chroma (rsp_chroma_u)
   );

   rbyuv_chroma u_chroma_v (
      .clock  (clock),
      .sum    (v_total_ff),
      .offset (offset_ff),
      .chroma (rsp_chroma_v)
   );

   assign rsp_strobe  = valid_ff[STAGES-1];
   assign rsp_luma_tl = luma4_ff[0];
   assign rsp_luma_tr = luma4_ff[1];
   assign rsp_luma_bl = luma4_ff[2];
   assign rsp_luma_br = luma4_ff[3];

endmodule
